// ===== hw/rtl/cat_map_pixel_scatter_macros.svh =====
// Assertion shorthands shared by the verification code of the pixel scatter.
`ifndef CAT_MAP_PIXEL_SCATTER_MACROS_SVH
`define CAT_MAP_PIXEL_SCATTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cat map scatter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cat map scatter: next-cycle check failed");

`endif

// ===== hw/rtl/cms_pkg.sv =====
package cms_pkg;

  // Fixed field widths of the pixel and result channels.
  localparam int unsigned CoordWidth   = 12;
  localparam int unsigned PixWidth     = 8;
  localparam int unsigned AddrWidth    = 24;

  // Configuration port.
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned PaddrWidth   = 3;
  localparam int unsigned SideWidth    = 13;
  localparam int unsigned IterWidth    = 7;

  localparam logic [SideWidth-1:0] SideReset = 13'd1024;
  localparam logic [IterWidth-1:0] IterReset = 7'd1;

  typedef enum logic {
    REG_SIDE_LENGTH     = 1'b0,
    REG_ITERATION_COUNT = 1'b1
  } reg_idx_e;

  // Control and pixel data that travel along with the coordinates.
  typedef struct packed {
    logic                valid;
    logic                err;
    logic [PixWidth-1:0] pix;
  } item_tag_t;

endpackage

// ===== hw/rtl/cms_cfg.sv =====
module cms_cfg #(
  parameter int unsigned MAX_SIDE = 4096,
  parameter int unsigned MAX_ITER = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cms_pkg::PaddrWidth-1:0]       paddr,
  input  logic [cms_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [cms_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                 pready,
  output logic [$clog2(MAX_SIDE+1)-1:0]        n_eff_o,
  output logic [$clog2(MAX_ITER+1)-1:0]        k_eff_o
);
  import cms_pkg::*;

  localparam int unsigned NW = $clog2(MAX_SIDE + 1);
  localparam int unsigned KW = $clog2(MAX_ITER + 1);

  logic [SideWidth-1:0] side_q;
  logic [IterWidth-1:0] iter_q;
  logic                 wr_en;
  reg_idx_e             idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideReset;
      iter_q <= IterReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_SIDE_LENGTH:     side_q <= pwdata[SideWidth-1:0];
        REG_ITERATION_COUNT: iter_q <= pwdata[IterWidth-1:0];
        default:             side_q <= side_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIDE_LENGTH:     prdata = CfgDataWidth'(side_q);
      REG_ITERATION_COUNT: prdata = CfgDataWidth'(iter_q);
      default:             prdata = '0;
    endcase
  end

  // A side of zero acts as one; sides and counts beyond the build limits saturate.
  always_comb begin
    if (side_q == '0) begin
      n_eff_o = NW'(1);
    end else if (32'(side_q) > 32'(MAX_SIDE)) begin
      n_eff_o = NW'(MAX_SIDE);
    end else begin
      n_eff_o = NW'(side_q);
    end
    if (32'(iter_q) > 32'(MAX_ITER)) begin
      k_eff_o = KW'(MAX_ITER);
    end else begin
      k_eff_o = KW'(iter_q);
    end
  end

endmodule

// ===== hw/rtl/cms_cell.sv =====
module cms_cell #(
  parameter int unsigned MAX_SIDE = 4096,
  parameter int unsigned MAX_ITER = 64,
  parameter int unsigned IDX      = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   n_i,
  input  logic [$clog2(MAX_ITER+1)-1:0]   k_i,
  input  cms_pkg::item_tag_t              tag_i,
  input  logic [$clog2(MAX_SIDE)-1:0]     x_i,
  input  logic [$clog2(MAX_SIDE)-1:0]     y_i,
  output cms_pkg::item_tag_t              tag_o,
  output logic [$clog2(MAX_SIDE)-1:0]     x_o,
  output logic [$clog2(MAX_SIDE)-1:0]     y_o
);
  import cms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned SW = CW + 2;
  localparam int unsigned KW = $clog2(MAX_ITER + 1);

  logic [SW-1:0] nn, sx, sx1, sx2, sy, sy1;
  logic          apply;
  item_tag_t     tag_q;
  logic [CW-1:0] x_q, y_q, x_d, y_d;

  // One step of the map; both sums stay below three times the side.
  always_comb begin
    nn    = SW'(n_i);
    sx    = (SW'(x_i) << 1) + SW'(y_i);
    sx1   = (sx >= nn) ? sx - nn : sx;
    sx2   = (sx1 >= nn) ? sx1 - nn : sx1;
    sy    = SW'(x_i) + SW'(y_i);
    sy1   = (sy >= nn) ? sy - nn : sy;
    apply = tag_i.valid && !tag_i.err && (k_i > KW'(IDX));
    x_d   = apply ? CW'(sx2) : x_i;
    y_d   = apply ? CW'(sy1) : y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign tag_o = tag_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule

// ===== hw/rtl/cms_addr.sv =====
module cms_addr #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]       n_i,
  input  cms_pkg::item_tag_t                  tag_i,
  input  logic [$clog2(MAX_SIDE)-1:0]         x_i,
  input  logic [$clog2(MAX_SIDE)-1:0]         y_i,
  output cms_pkg::item_tag_t                  tag_o,
  output logic [cms_pkg::CoordWidth-1:0]      dest_x_o,
  output logic [cms_pkg::CoordWidth-1:0]      dest_y_o,
  output logic [cms_pkg::AddrWidth-1:0]       dest_addr_o
);
  import cms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned NW = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW = CW + NW;

  item_tag_t              tag_a_q, tag_b_q;
  logic [CW-1:0]          x_a_q, y_a_q;
  logic [AW-1:0]          prod_a_q, sum_b;
  logic [CoordWidth-1:0]  x_b_q, y_b_q;
  logic [AddrWidth-1:0]   addr_b_q;

  // First stage forms the row offset, second stage adds the column.
  assign sum_b = AW'(x_a_q) + prod_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else if (adv_i) begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_a_q    <= x_i;
      y_a_q    <= y_i;
      prod_a_q <= AW'(y_i) * AW'(n_i);
      if (tag_a_q.err) begin
        x_b_q    <= '0;
        y_b_q    <= '0;
        addr_b_q <= '0;
      end else begin
        x_b_q    <= CoordWidth'(x_a_q);
        y_b_q    <= CoordWidth'(y_a_q);
        addr_b_q <= AddrWidth'(sum_b);
      end
    end
  end

  assign tag_o       = tag_b_q;
  assign dest_x_o    = x_b_q;
  assign dest_y_o    = y_b_q;
  assign dest_addr_o = addr_b_q;

endmodule

// ===== hw/rtl/cat_map_pixel_scatter.sv =====
// Arnold cat map pixel scatter. Each transfer on the source channel carries one pixel and its
// coordinates in an N x N image; the block applies x' = (2x + y) mod N, y' = (x + y) mod N
// k times and returns the destination column, row, row-major address (x + y * N) and the
// unchanged pixel. N and k come from the side_length (byte address 0) and iteration_count
// (byte address 4) registers; a side of zero acts as one, and values beyond MAX_SIDE or
// MAX_ITER saturate. A source coordinate not below N sets coord_error and forces the
// destination fields to zero. The datapath is an input register, a chain of MAX_ITER
// identical map cells with one register stage each, and a two-stage address unit, so a new
// pixel is taken every cycle while the result register is free or being taken. Every result
// passes through all of these registers, independent of k: cells beyond the k-th simply
// pass the coordinates on. The whole chain advances together, so when the result register
// is full and not taken, the source channel stalls as well.
// Configuration must only be written while no pixel is in flight.
module cat_map_pixel_scatter #(
  parameter int unsigned MAX_SIDE = 4096,
  parameter int unsigned MAX_ITER = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cms_pkg::PaddrWidth-1:0]       paddr,
  input  logic [cms_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [cms_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                 pready,
  // Source pixel channel.
  input  logic                                 src_valid_i,
  output logic                                 src_ready_o,
  input  logic [cms_pkg::CoordWidth-1:0]       src_x_i,
  input  logic [cms_pkg::CoordWidth-1:0]       src_y_i,
  input  logic [cms_pkg::PixWidth-1:0]         pixel_in_i,
  // Destination channel.
  output logic                                 dest_valid_o,
  input  logic                                 dest_ready_i,
  output logic [cms_pkg::CoordWidth-1:0]       dest_x_o,
  output logic [cms_pkg::CoordWidth-1:0]       dest_y_o,
  output logic [cms_pkg::AddrWidth-1:0]        dest_address_o,
  output logic [cms_pkg::PixWidth-1:0]         pixel_out_o,
  output logic                                 coord_error_o
);
  import cms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned NW = $clog2(MAX_SIDE + 1);
  localparam int unsigned KW = $clog2(MAX_ITER + 1);

  logic [NW-1:0] n_eff;
  logic [KW-1:0] k_eff;
  logic          adv;
  logic          in_err;

  item_tag_t     in_tag_q;
  logic [CW-1:0] in_x_q, in_y_q;

  item_tag_t     tag_c [MAX_ITER+1];
  logic [CW-1:0] x_c   [MAX_ITER+1];
  logic [CW-1:0] y_c   [MAX_ITER+1];
  item_tag_t     out_tag;

  cms_cfg #(
    .MAX_SIDE (MAX_SIDE),
    .MAX_ITER (MAX_ITER)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_eff_o (n_eff),
    .k_eff_o (k_eff)
  );

  // The pipeline moves as one unit whenever the result register can take a new value.
  assign adv         = !out_tag.valid || dest_ready_i;
  assign src_ready_o = adv;

  // Range check happens at entry; an out-of-range pixel rides through the chain untouched.
  assign in_err = (32'(src_x_i) >= 32'(n_eff)) || (32'(src_y_i) >= 32'(n_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= '0;
    end else if (adv) begin
      in_tag_q.valid <= src_valid_i;
      in_tag_q.err   <= in_err;
      in_tag_q.pix   <= pixel_in_i;
    end
  end

  // Coordinates are only meaningful below N, which never exceeds MAX_SIDE.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_x_q <= CW'(src_x_i);
      in_y_q <= CW'(src_y_i);
    end
  end

  assign tag_c[0] = in_tag_q;
  assign x_c[0]   = in_x_q;
  assign y_c[0]   = in_y_q;

  // Cell j performs the (j+1)-th map step when k is larger than j, else it passes through.
  for (genvar j = 0; j < MAX_ITER; j++) begin : g_cell
    cms_cell #(
      .MAX_SIDE (MAX_SIDE),
      .MAX_ITER (MAX_ITER),
      .IDX      (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .n_i    (n_eff),
      .k_i    (k_eff),
      .tag_i  (tag_c[j]),
      .x_i    (x_c[j]),
      .y_i    (y_c[j]),
      .tag_o  (tag_c[j+1]),
      .x_o    (x_c[j+1]),
      .y_o    (y_c[j+1])
    );
  end

  cms_addr #(
    .MAX_SIDE (MAX_SIDE)
  ) u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .n_i         (n_eff),
    .tag_i       (tag_c[MAX_ITER]),
    .x_i         (x_c[MAX_ITER]),
    .y_i         (y_c[MAX_ITER]),
    .tag_o       (out_tag),
    .dest_x_o    (dest_x_o),
    .dest_y_o    (dest_y_o),
    .dest_addr_o (dest_address_o)
  );

  assign dest_valid_o  = out_tag.valid;
  assign pixel_out_o   = out_tag.pix;
  assign coord_error_o = out_tag.err;

endmodule

// ===== hw/rtl/cms_assert_mon.sv =====
`include "cat_map_pixel_scatter_macros.svh"

module cms_assert_mon (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              src_valid_i,
  input logic                              src_ready_o,
  input logic                              dest_valid_o,
  input logic                              dest_ready_i,
  input logic [cms_pkg::CoordWidth-1:0]    dest_x_o,
  input logic [cms_pkg::CoordWidth-1:0]    dest_y_o,
  input logic [cms_pkg::AddrWidth-1:0]     dest_address_o,
  input logic [cms_pkg::PixWidth-1:0]      pixel_out_o,
  input logic                              coord_error_o
);
  import cms_pkg::*;

  // A pending result stays offered until it is taken.
  `CMS_ASSERT_NXT(a_dest_hold, dest_valid_o && !dest_ready_i, dest_valid_o)

  // A stalled result keeps its payload.
  `CMS_ASSERT_NXT(a_dest_stable, dest_valid_o && !dest_ready_i, $stable(dest_address_o) && $stable(pixel_out_o))

  // The source side only stalls while a finished result waits to be taken.
  `CMS_ASSERT_IMP(a_src_stall, !src_ready_o, dest_valid_o && !dest_ready_i)

  // A flagged pixel carries no destination.
  `CMS_ASSERT_IMP(a_err_zero, dest_valid_o && coord_error_o, dest_x_o == '0 && dest_y_o == '0 && dest_address_o == '0)

endmodule

bind cat_map_pixel_scatter cms_assert_mon u_assert_mon (.*);

// ===== bench/cat_map_pixel_scatter_tb.sv =====
`timescale 1ns / 1ps

module cat_map_pixel_scatter_tb;
  import cms_pkg::*;

  // Geometry limits of the block as instantiated, and its fixed pipeline depth.
  localparam int unsigned MaxSide     = 4096;
  localparam int unsigned MaxIter     = 64;
  localparam int unsigned PipeLatency = MaxIter + 3;
  // Quiet cycles granted after the last result, before a register write or the end.
  localparam int unsigned SettleCycles = PipeLatency + 16;
  // Upper bound on the whole run. The slowest legal run is 916 pixels, each
  // waiting out long gaps on both sides, plus a full pipeline drain around every
  // configuration change. That stays far below this figure.
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PixelsPerPhase = 112;

  // One result as it leaves the destination channel.
  typedef struct packed {
    logic [CoordWidth-1:0] x;
    logic [CoordWidth-1:0] y;
    logic [AddrWidth-1:0]  addr;
    logic [PixWidth-1:0]   pix;
    logic                  err;
  } dest_t;

  // Keeps a copy of both registers, predicts where every accepted pixel lands and
  // compares the results, in order, against those predictions.
  class cat_map_scoreboard;
    logic [SideWidth-1:0] side_q;
    logic [IterWidth-1:0] iter_q;
    dest_t                pending_dest[$];
    int unsigned          fails;

    function new();
      side_q = SideReset;
      iter_q = IterReset;
      fails  = 0;
    endfunction

    function void write_register(reg_idx_e idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_SIDE_LENGTH:     side_q = data[SideWidth-1:0];
        REG_ITERATION_COUNT: iter_q = data[IterWidth-1:0];
        default: ;
      endcase
    endfunction

    // Side length as the block uses it: zero acts as one, large values saturate.
    function int unsigned side();
      int unsigned n;
      n = side_q;
      if (n == 0) n = 1;
      if (n > MaxSide) n = MaxSide;
      return n;
    endfunction

    function int unsigned iterations();
      int unsigned k;
      k = iter_q;
      if (k > MaxIter) k = MaxIter;
      return k;
    endfunction

    function dest_t map_pixel(logic [CoordWidth-1:0] sx, logic [CoordWidth-1:0] sy,
                              logic [PixWidth-1:0] pix);
      dest_t       d;
      int unsigned n, k, x, y, nx, ny;
      n = side();
      k = iterations();
      x = sx;
      y = sy;
      d.pix = pix;
      if (x >= n || y >= n) begin
        d.x    = '0;
        d.y    = '0;
        d.addr = '0;
        d.err  = 1'b1;
        return d;
      end
      for (int unsigned i = 0; i < k; i++) begin
        // 2x + y stays below 3N, so two conditional subtractions reduce it.
        nx = 2 * x + y;
        ny = x + y;
        if (nx >= n) nx -= n;
        if (nx >= n) nx -= n;
        if (ny >= n) ny -= n;
        x = nx;
        y = ny;
      end
      d.x    = x[CoordWidth-1:0];
      d.y    = y[CoordWidth-1:0];
      d.addr = AddrWidth'(x + y * n);
      d.err  = 1'b0;
      return d;
    endfunction

    function void note_source(logic [CoordWidth-1:0] sx, logic [CoordWidth-1:0] sy,
                              logic [PixWidth-1:0] pix);
      pending_dest.push_back(map_pixel(sx, sy, pix));
    endfunction

    function void check_destination(dest_t got);
      dest_t want;
      if (pending_dest.size() == 0) begin
        $error("result transfer with no pixel outstanding: dest_x %0d dest_y %0d",
               got.x, got.y);
        fails++;
        return;
      end
      want = pending_dest.pop_front();
      if (got.x !== want.x) begin
        $error("dest_x: expected %0d, actual %0d", want.x, got.x);
        fails++;
      end
      if (got.y !== want.y) begin
        $error("dest_y: expected %0d, actual %0d", want.y, got.y);
        fails++;
      end
      if (got.addr !== want.addr) begin
        $error("dest_address: expected %0d, actual %0d", want.addr, got.addr);
        fails++;
      end
      if (got.pix !== want.pix) begin
        $error("pixel_out: expected %0d, actual %0d", want.pix, got.pix);
        fails++;
      end
      if (got.err !== want.err) begin
        $error("coord_error: expected %0d, actual %0d", want.err, got.err);
        fails++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PaddrWidth-1:0]   paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  logic                    src_valid_i;
  logic                    src_ready_o;
  logic [CoordWidth-1:0]   src_x_i;
  logic [CoordWidth-1:0]   src_y_i;
  logic [PixWidth-1:0]     pixel_in_i;
  logic                    dest_valid_o;
  logic                    dest_ready_i;
  logic [CoordWidth-1:0]   dest_x_o;
  logic [CoordWidth-1:0]   dest_y_o;
  logic [AddrWidth-1:0]    dest_address_o;
  logic [PixWidth-1:0]     pixel_out_o;
  logic                    coord_error_o;

  cat_map_scoreboard sb = new();

  // Percentages of cycles in which the source holds back a pixel and the sink
  // refuses a result. They change over the run so that both sides take turns
  // being the bottleneck, followed by a stretch at full rate.
  int unsigned src_gap_pct;
  int unsigned dest_stall_pct;
  int unsigned pixels_sent;
  int unsigned cycle_count;

  cat_map_pixel_scatter #(
    .MAX_SIDE(MaxSide),
    .MAX_ITER(MaxIter)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .src_valid_i   (src_valid_i),
    .src_ready_o   (src_ready_o),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .pixel_in_i    (pixel_in_i),
    .dest_valid_o  (dest_valid_o),
    .dest_ready_i  (dest_ready_i),
    .dest_x_o      (dest_x_o),
    .dest_y_o      (dest_y_o),
    .dest_address_o(dest_address_o),
    .pixel_out_o   (pixel_out_o),
    .coord_error_o (coord_error_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The run is bounded here; a hang anywhere ends as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The sink decides at every falling edge whether it takes a result in the next cycle.
  always @(negedge clk_i) begin
    dest_ready_i <= (dest_stall_pct == 0) || ($urandom_range(0, 99) >= dest_stall_pct);
  end

  // Both channels are observed at the rising edge, where transfers take place.
  // Registers only change while the pipeline is empty, so the prediction made at
  // acceptance time uses the configuration that the block applies.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_valid_i && src_ready_o) begin
        sb.note_source(src_x_i, src_y_i, pixel_in_i);
      end
      if (dest_valid_o && dest_ready_i) begin
        sb.check_destination({dest_x_o, dest_y_o, dest_address_o, pixel_out_o,
                              coord_error_o});
      end
    end
  end

  // Picks the gap rates from how far into the stimulus we are.
  task automatic update_idling();
    if (pixels_sent < 300) begin
      src_gap_pct    = 36;
      dest_stall_pct = 68;
    end else if (pixels_sent < 600) begin
      src_gap_pct    = 68;
      dest_stall_pct = 36;
    end else begin
      src_gap_pct    = 0;
      dest_stall_pct = 0;
    end
  endtask

  // Offers one pixel, possibly after some idle cycles, and returns once it is taken.
  task automatic send_pixel(logic [CoordWidth-1:0] x, logic [CoordWidth-1:0] y,
                            logic [PixWidth-1:0] pix);
    update_idling();
    @(negedge clk_i);
    while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      src_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    src_valid_i <= 1'b1;
    src_x_i     <= x;
    src_y_i     <= y;
    pixel_in_i  <= pix;
    do @(posedge clk_i); while (!src_ready_o);
    pixels_sent++;
  endtask

  // Lowers valid and waits until every outstanding pixel has come back, then lets
  // the pipeline settle.
  task automatic drain_pipeline();
    @(negedge clk_i);
    src_valid_i <= 1'b0;
    while (sb.pending_dest.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write in a setup phase, then an access phase, committed at the rising edge
  // where the access phase meets pready.
  task automatic write_register(reg_idx_e idx, logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drains the block, then writes both registers.
  task automatic configure(logic [CfgDataWidth-1:0] side_word,
                           logic [CfgDataWidth-1:0] iter_word);
    drain_pipeline();
    write_register(REG_SIDE_LENGTH, side_word);
    write_register(REG_ITERATION_COUNT, iter_word);
  endtask

  // Coordinate that is mostly inside the current image, now and then anywhere.
  function automatic logic [CoordWidth-1:0] pick_coord();
    if ($urandom_range(0, 3) == 0) return CoordWidth'($urandom_range(0, 4095));
    return CoordWidth'($urandom_range(0, sb.side() - 1));
  endfunction

  initial begin
    logic [CfgDataWidth-1:0] side_word;
    logic [CfgDataWidth-1:0] iter_word;

    cycle_count    = 0;
    pixels_sent    = 0;
    src_gap_pct    = 36;
    dest_stall_pct = 68;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    src_valid_i    = 1'b0;
    src_x_i        = '0;
    src_y_i        = '0;
    pixel_in_i     = '0;
    dest_ready_i   = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: a 1024-pixel side with a single map step. The last three
    // pixels fall outside the image on one or both axes.
    send_pixel(12'd0, 12'd0, 8'd0);
    send_pixel(12'd1023, 12'd1023, 8'd255);
    send_pixel(12'd1024, 12'd5, 8'd7);
    send_pixel(12'd5, 12'd1024, 8'd128);
    send_pixel(12'd4095, 12'd4095, 8'd1);

    // Largest image with the deepest iteration count.
    configure(32'd4096, 32'd64);
    send_pixel(12'd4095, 12'd4095, 8'd255);
    send_pixel(12'd0, 12'd4095, 8'd0);
    send_pixel(12'd4095, 12'd0, 8'd170);
    send_pixel(12'd2048, 12'd2048, 8'd85);

    // A side of zero behaves as a single-pixel image; with no iterations the only
    // legal pixel stays put.
    configure(32'd0, 32'd0);
    send_pixel(12'd0, 12'd0, 8'd255);
    send_pixel(12'd1, 12'd0, 8'd3);
    send_pixel(12'd0, 12'd1, 8'd4);

    // Oversized side and iteration count both saturate.
    configure(32'd8191, 32'd127);
    send_pixel(12'd4095, 12'd4095, 8'd9);
    send_pixel(12'd1, 12'd1, 8'd10);
    send_pixel(12'd4095, 12'd1, 8'd11);

    // Only the register width of the write data counts; the rest is junk.
    configure(32'hFFFF_E007, 32'hFFFF_FF83);
    send_pixel(12'd6, 12'd6, 8'd12);
    send_pixel(12'd7, 12'd0, 8'd13);
    send_pixel(12'd3, 12'd4, 8'd14);

    // Zero iterations on the full image: every destination equals its source.
    configure(32'd4096, 32'd0);
    send_pixel(12'd4095, 12'd4095, 8'd15);
    send_pixel(12'd123, 12'd456, 8'd16);

    // Random phases, each with its own configuration, the extremes among them.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 5))
        0:       side_word = 32'd0;
        1:       side_word = 32'd4096;
        2:       side_word = $urandom_range(4097, 8191);
        3:       side_word = $urandom_range(1, 16);
        default: side_word = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 4))
        0:       iter_word = 32'd0;
        1:       iter_word = 32'd64;
        2:       iter_word = $urandom_range(65, 127);
        default: iter_word = $urandom_range(0, 64);
      endcase
      // Random high-order junk exercises the masking of every write data bit.
      side_word |= $urandom() & ~32'h1FFF;
      iter_word |= $urandom() & ~32'h7F;
      configure(side_word, iter_word);
      for (int unsigned i = 0; i < PixelsPerPhase; i++) begin
        // Once in mid-phase the source holds off until the pipeline has emptied.
        if (phase == 2 && i == PixelsPerPhase / 2) drain_pipeline();
        send_pixel(pick_coord(), pick_coord(), PixWidth'($urandom_range(0, 255)));
      end
    end

    drain_pipeline();
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== cat_map_pixel_scatter.f =====
+incdir+hw/rtl
hw/rtl/cms_pkg.sv
hw/rtl/cms_cfg.sv
hw/rtl/cms_cell.sv
hw/rtl/cms_addr.sv
hw/rtl/cat_map_pixel_scatter.sv
hw/rtl/cms_assert_mon.sv
bench/cat_map_pixel_scatter_tb.sv
